// ===== rtl/core/mbs_pkg.sv =====
// shared types, codes and the letter keying table of the morse beacon sequencer
package mbs_pkg;

	// request function codes
	typedef enum logic [1:0] {
		FUNC_TICK  = 2'd0,
		FUNC_WRITE = 2'd1,
		FUNC_START = 2'd2,
		FUNC_STOP  = 2'd3
	} func_t;

	// keying pattern of one character, lowest bit sent first
	typedef struct packed {
		logic [15:0] pattern;
		logic [4:0]  count;
	} letter_t;

	// one result request
	typedef struct packed {
		logic led_level;
		logic playing;
	} result_t;

	localparam logic [7:0] CHAR_NUL = 8'h00;
	localparam logic [7:0] CHAR_A   = 8'h41;
	localparam logic [7:0] CHAR_Z   = 8'h5A;
	localparam logic [4:0] BLANK_BITS = 5'd4;

	// pattern and bit count for any character; non-letters give four low bits
	function automatic letter_t char_code(input logic [7:0] c);
		letter_t    lc;
		logic [7:0] idx;
		lc  = '{pattern: 16'h0000, count: BLANK_BITS};
		idx = c - CHAR_A;
		if (c >= CHAR_A && c <= CHAR_Z) begin
			case (idx[4:0])
				5'd0:    lc = '{16'h001D,  5'd8};
				5'd1:    lc = '{16'h0157, 5'd12};
				5'd2:    lc = '{16'h05D7, 5'd14};
				5'd3:    lc = '{16'h0057, 5'd10};
				5'd4:    lc = '{16'h0001,  5'd4};
				5'd5:    lc = '{16'h0175, 5'd12};
				5'd6:    lc = '{16'h0177, 5'd12};
				5'd7:    lc = '{16'h0055, 5'd10};
				5'd8:    lc = '{16'h0005,  5'd6};
				5'd9:    lc = '{16'h1DDD, 5'd16};
				5'd10:   lc = '{16'h01D7, 5'd12};
				5'd11:   lc = '{16'h015D, 5'd12};
				5'd12:   lc = '{16'h0077, 5'd10};
				5'd13:   lc = '{16'h0017,  5'd8};
				5'd14:   lc = '{16'h0777, 5'd14};
				5'd15:   lc = '{16'h05DD, 5'd14};
				5'd16:   lc = '{16'h1D77, 5'd16};
				5'd17:   lc = '{16'h005D, 5'd10};
				5'd18:   lc = '{16'h0015,  5'd8};
				5'd19:   lc = '{16'h0007,  5'd6};
				5'd20:   lc = '{16'h0075, 5'd10};
				5'd21:   lc = '{16'h01D5, 5'd12};
				5'd22:   lc = '{16'h01DD, 5'd12};
				5'd23:   lc = '{16'h0757, 5'd14};
				5'd24:   lc = '{16'h1DD7, 5'd16};
				5'd25:   lc = '{16'h0577, 5'd14};
				default: lc = '{pattern: 16'h0000, count: BLANK_BITS};
			endcase
		end
		return lc;
	endfunction

endpackage

// ===== rtl/core/mbs_if.sv =====
// request and result channel interfaces of the morse beacon sequencer

// request channel
interface mbs_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [4:0] char_index;
	logic [7:0] char_value;
	logic       repeat_flag;

	modport source (output valid, output func, output char_index, output char_value,
		output repeat_flag, input ready);
	modport sink (input valid, input func, input char_index, input char_value,
		input repeat_flag, output ready);
endinterface

// result channel
interface mbs_res_if;
	logic valid;
	logic ready;
	logic led_level;
	logic playing;

	modport source (output valid, output led_level, output playing, input ready);
	modport sink (input valid, input led_level, input playing, output ready);
endinterface

// ===== rtl/core/mbs_out_buf.sv =====
// two-entry result buffer parting the request side from the result side
module mbs_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  mbs_pkg::result_t  push_data,
	output logic              can_push,
	mbs_res_if.source         res
);

	logic [1:0]       cnt_q;
	logic [1:0]       cnt_d;
	logic [1:0]       wr_slot;
	logic             pop;
	mbs_pkg::result_t e0_q;
	mbs_pkg::result_t e1_q;

	// handshake and occupancy
	assign pop       = res.valid && res.ready;
	assign can_push  = (cnt_q != 2'd2);
	assign res.valid = (cnt_q != 2'd0);
	assign res.led_level = e0_q.led_level;
	assign res.playing   = e0_q.playing;
	assign wr_slot   = pop ? (cnt_q - 2'd1) : cnt_q;

	always_comb begin
		cnt_d = cnt_q;
		if (push && !pop) begin
			cnt_d = cnt_q + 2'd1;
		end else if (pop && !push) begin
			cnt_d = cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_d;
		end
	end

	// entry storage, head shifts on a pop
	always_ff @(posedge clk) begin
		if (pop && cnt_q == 2'd2) begin
			e0_q <= e1_q;
		end
		if (push) begin
			if (wr_slot == 2'd0) begin
				e0_q <= push_data;
			end else begin
				e1_q <= push_data;
			end
		end
	end

endmodule

// ===== rtl/core/morse_beacon_sequencer.sv =====
// top level: message store, playback state and keying of the morse beacon sequencer
// a result is offered in the cycle after its request is accepted when the result buffer is empty
// throughput: one request per cycle, stalled only while two results wait in the buffer;
//   the store read for the next fetch is issued from the next read position, a same-cycle write forwarded
// reset: asynchronous, clears all control state and the per-entry valid bits of the store,
//   so unwritten entries read as NUL at once with no clearing pass
module morse_beacon_sequencer #(
	parameter int MSG_DEPTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	mbs_cmd_if.sink   cmd,
	mbs_res_if.source res
);

	localparam int POS_W  = $clog2(MSG_DEPTH + 1);
	localparam int ADDR_W = $clog2(MSG_DEPTH);
	localparam logic [POS_W-1:0] POS_END = POS_W'(MSG_DEPTH);

	// message store and its registered read
	logic [7:0]           mem_q [MSG_DEPTH];
	logic [MSG_DEPTH-1:0] valid_q;
	logic [7:0]           rd_q;
	logic                 rd_vld_q;
	logic [7:0]           char0_q;
	logic [ADDR_W-1:0]    rd_addr;
	logic [ADDR_W-1:0]    waddr;
	logic                 we;

	// playback state
	logic [POS_W-1:0] pos_q, pos_d, pos_inc;
	logic [15:0]      pat_q, pat_d, shift_src;
	logic [4:0]       bits_q, bits_d, cnt_src;
	logic             led_q, led_d;
	logic             act_q, act_d;
	logic             rep_q, rep_d;

	logic             acc;
	logic             can_push;
	mbs_pkg::func_t   func;
	logic [7:0]       cur_char;
	logic [7:0]       sel_char;
	mbs_pkg::letter_t lc;
	mbs_pkg::result_t push_data;

	assign acc  = cmd.valid && cmd.ready;
	assign func = mbs_pkg::func_t'(cmd.func);
	assign cmd.ready = can_push;

	// store write decode, out of range positions dropped
	assign waddr = ADDR_W'(cmd.char_index);
	assign we    = acc && (func == mbs_pkg::FUNC_WRITE) &&
		(32'(cmd.char_index) < 32'(MSG_DEPTH));

	// character at the read position, NUL past the end of the store
	assign cur_char = (pos_q < POS_END && rd_vld_q) ? rd_q : mbs_pkg::CHAR_NUL;
	assign sel_char = (cur_char == mbs_pkg::CHAR_NUL) ? char0_q : cur_char;
	assign lc       = mbs_pkg::char_code(sel_char);
	assign pos_inc  = (pos_q < POS_END) ? (pos_q + POS_W'(1)) : pos_q;

	// next state for one request
	always_comb begin
		pos_d     = pos_q;
		pat_d     = pat_q;
		bits_d    = bits_q;
		led_d     = led_q;
		act_d     = act_q;
		rep_d     = rep_q;
		shift_src = pat_q;
		cnt_src   = bits_q;
		if (acc) begin
			case (func)
				mbs_pkg::FUNC_TICK: begin
					if (act_q) begin
						if (bits_q == 5'd0 && cur_char == mbs_pkg::CHAR_NUL && !rep_q) begin
							// message end, single play
							act_d = 1'b0;
							pos_d = pos_inc;
						end else begin
							if (bits_q == 5'd0) begin
								shift_src = lc.pattern;
								cnt_src   = lc.count;
								if (cur_char == mbs_pkg::CHAR_NUL) begin
									// wrap to the start of the message
									pos_d = (char0_q == mbs_pkg::CHAR_NUL) ? '0 : POS_W'(1);
								end else begin
									pos_d = pos_inc;
								end
							end
							led_d  = shift_src[0];
							pat_d  = shift_src >> 1;
							bits_d = cnt_src - 5'd1;
						end
					end
				end
				mbs_pkg::FUNC_START: begin
					led_d = 1'b0;
					pos_d = '0;
					rep_d = cmd.repeat_flag;
					act_d = 1'b1;
				end
				mbs_pkg::FUNC_STOP: begin
					led_d = 1'b0;
					act_d = 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// prefetch address follows the next read position
	assign rd_addr = (pos_d < POS_END) ? ADDR_W'(pos_d) : '0;

	// control and playback registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			pat_q    <= '0;
			bits_q   <= '0;
			led_q    <= 1'b0;
			act_q    <= 1'b0;
			rep_q    <= 1'b0;
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
			char0_q  <= mbs_pkg::CHAR_NUL;
		end else begin
			pos_q  <= pos_d;
			pat_q  <= pat_d;
			bits_q <= bits_d;
			led_q  <= led_d;
			act_q  <= act_d;
			rep_q  <= rep_d;
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			rd_vld_q <= (we && waddr == rd_addr) ? 1'b1 : valid_q[rd_addr];
			if (we && waddr == '0) begin
				char0_q <= cmd.char_value;
			end
		end
	end

	// store array, write-first read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= cmd.char_value;
		end
		if (we && waddr == rd_addr) begin
			rd_q <= cmd.char_value;
		end else begin
			rd_q <= mem_q[rd_addr];
		end
	end

	// result buffer
	assign push_data = '{led_level: led_d, playing: act_d};

	mbs_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (acc),
		.push_data (push_data),
		.can_push  (can_push),
		.res       (res)
	);

	// checks
	a_stop_idles: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && func == mbs_pkg::FUNC_STOP) |=> (!act_q && !led_q))
		else $error("stop request did not idle playback");

	a_bits_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bits_q <= 5'd16)
		else $error("bit count beyond longest pattern");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_END)
		else $error("read position beyond end of store");

	a_idle_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && func == mbs_pkg::FUNC_TICK && !act_q) |=>
		($stable(pos_q) && $stable(bits_q) && $stable(pat_q) && $stable(led_q)))
		else $error("tick while idle changed playback state");

endmodule

// ===== tb/morse_beacon_sequencer_test.sv =====
// self-checking testbench of the morse beacon sequencer: random requests against a keying predictor
`timescale 1ns / 1ps

module morse_beacon_sequencer_test;

	localparam int DEPTH         = 32;
	localparam int DIRECTED_MAX  = 26;
	localparam int RANDOM_ITEMS  = 1950;
	localparam int STALL_LIMIT   = 2000;
	localparam int DRAIN_CYCLES  = 4;
	localparam int CALM_FROM     = 600;
	localparam int CALM_TO       = 1100;

	// keying patterns and lengths of A to Z, lowest bit first
	localparam logic [15:0] KEY_PATTERN [26] = '{
		16'h001D, 16'h0157, 16'h05D7, 16'h0057, 16'h0001, 16'h0175, 16'h0177,
		16'h0055, 16'h0005, 16'h1DDD, 16'h01D7, 16'h015D, 16'h0077, 16'h0017,
		16'h0777, 16'h05DD, 16'h1D77, 16'h005D, 16'h0015, 16'h0007, 16'h0075,
		16'h01D5, 16'h01DD, 16'h0757, 16'h1DD7, 16'h0577
	};
	localparam logic [4:0] KEY_LEN [26] = '{
		5'd8, 5'd12, 5'd14, 5'd10, 5'd4, 5'd12, 5'd12, 5'd10, 5'd6, 5'd16,
		5'd12, 5'd12, 5'd10, 5'd8, 5'd14, 5'd14, 5'd16, 5'd10, 5'd8, 5'd6,
		5'd10, 5'd12, 5'd12, 5'd14, 5'd16, 5'd14
	};

	typedef struct packed {
		mbs_pkg::func_t func;
		logic [4:0]     char_index;
		logic [7:0]     char_value;
		logic           repeat_flag;
	} request_t;

	logic clk;
	logic arst_n = 1'b0;

	mbs_cmd_if cmd_ch ();
	mbs_res_if res_ch ();

	morse_beacon_sequencer #(
		.MSG_DEPTH(DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.res(res_ch)
	);

	// driven copies of the channel inputs, known from time zero
	logic     drv_valid = 1'b0;
	request_t drv_req   = '0;
	logic     mon_ready = 1'b0;

	assign cmd_ch.valid       = drv_valid;
	assign cmd_ch.func        = drv_req.func;
	assign cmd_ch.char_index  = drv_req.char_index;
	assign cmd_ch.char_value  = drv_req.char_value;
	assign cmd_ch.repeat_flag = drv_req.repeat_flag;
	assign res_ch.ready       = mon_ready;

	request_t          pending_requests [$];
	mbs_pkg::result_t  expected_levels [$];
	mbs_pkg::result_t  want_level;
	int       mismatches  = 0;
	int       cycle_count = 0;
	int       quiet_cycles = 0;

	// predictor state
	logic [7:0]  msg_copy [DEPTH];
	logic [5:0]  read_pos    = '0;
	logic [15:0] key_shift   = '0;
	logic [4:0]  bits_left   = '0;
	logic        led_now     = 1'b0;
	logic        playing_now = 1'b0;
	logic        replay_on   = 1'b0;

	initial begin
		for (int i = 0; i < DEPTH; i++) msg_copy[i] = mbs_pkg::CHAR_NUL;
	end

	// store read, past the end reads as nul
	function automatic logic [7:0] char_at(logic [5:0] pos);
		return (pos >= DEPTH) ? mbs_pkg::CHAR_NUL : msg_copy[pos[4:0]];
	endfunction

	// line level and playing flag after one request
	function automatic mbs_pkg::result_t keyer_result(request_t req);
		mbs_pkg::result_t r;
		logic [7:0]       c;
		logic             send;
		logic [4:0]       k;
		case (req.func)
			mbs_pkg::FUNC_TICK: begin
				if (playing_now) begin
					send = 1'b1;
					if (bits_left == 5'd0) begin
						c = char_at(read_pos);
						if (read_pos < DEPTH) read_pos = read_pos + 6'd1;
						// message end: idle when played once, else wrap to the start
						if (c == mbs_pkg::CHAR_NUL) begin
							if (!replay_on) begin
								playing_now = 1'b0;
								send = 1'b0;
							end else begin
								c = char_at(6'd0);
								read_pos = (c == mbs_pkg::CHAR_NUL) ? 6'd0 : 6'd1;
							end
						end
						if (send) begin
							if (c >= mbs_pkg::CHAR_A && c <= mbs_pkg::CHAR_Z) begin
								k = 5'(c - mbs_pkg::CHAR_A);
								key_shift = KEY_PATTERN[k];
								bits_left = KEY_LEN[k];
							end else begin
								key_shift = '0;
								bits_left = mbs_pkg::BLANK_BITS;
							end
						end
					end
					if (send) begin
						led_now = key_shift[0];
						key_shift = key_shift >> 1;
						bits_left = bits_left - 5'd1;
					end
				end
			end
			mbs_pkg::FUNC_WRITE: begin
				if (req.char_index < DEPTH) msg_copy[req.char_index] = req.char_value;
			end
			mbs_pkg::FUNC_START: begin
				led_now = 1'b0;
				read_pos = '0;
				replay_on = req.repeat_flag;
				playing_now = 1'b1;
			end
			default: begin
				led_now = 1'b0;
				playing_now = 1'b0;
			end
		endcase
		r.led_level = led_now;
		r.playing = playing_now;
		return r;
	endfunction

	// random gap on either side, none inside the calm window
	function automatic bit take_gap();
		if (cycle_count >= CALM_FROM && cycle_count < CALM_TO) return 1'b0;
		return $urandom_range(0, 99) < 17;
	endfunction

	task automatic add_request(mbs_pkg::func_t f, logic [4:0] idx, logic [7:0] val, logic rep);
		request_t req;
		req.func = f;
		req.char_index = idx;
		req.char_value = val;
		req.repeat_flag = rep;
		pending_requests.push_back(req);
	endtask

	task automatic add_ticks(int n);
		for (int i = 0; i < n; i++)
			add_request(mbs_pkg::FUNC_TICK, 5'($urandom), 8'($urandom), 1'($urandom));
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drv_valid <= 1'b0;
		end else begin
			if (drv_valid && cmd_ch.ready) begin
				expected_levels.push_back(keyer_result(drv_req));
			end
			if (!drv_valid || cmd_ch.ready) begin
				if (pending_requests.size() != 0 && !take_gap()) begin
					drv_req <= pending_requests.pop_front();
					drv_valid <= 1'b1;
				end else begin
					drv_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mon_ready <= 1'b0;
		end else begin
			if (res_ch.valid && mon_ready) begin
				if (expected_levels.size() == 0) begin
					$display("%0t: result with none expected: led_level %0b playing %0b",
						$time, res_ch.led_level, res_ch.playing);
					mismatches++;
				end else begin
					want_level = expected_levels.pop_front();
					if (res_ch.led_level !== want_level.led_level) begin
						$display("%0t: led_level expected %0b actual %0b",
							$time, want_level.led_level, res_ch.led_level);
						mismatches++;
					end
					if (res_ch.playing !== want_level.playing) begin
						$display("%0t: playing expected %0b actual %0b",
							$time, want_level.playing, res_ch.playing);
						mismatches++;
					end
				end
			end
			mon_ready <= !take_gap();
		end
	end

	// watchdog on cycles with no handshake
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (arst_n) begin
			if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// stimulus, reset and end of run
	initial begin
		int         kind;
		int         len;
		int         budget;
		int         n;
		logic [7:0] ch;
		logic       rep;

		// idle tick, empty message once and with repeat
		add_request(mbs_pkg::FUNC_TICK, 5'd0, 8'h00, 1'b0);
		add_request(mbs_pkg::FUNC_START, 5'd31, 8'hFF, 1'b0);
		add_request(mbs_pkg::FUNC_TICK, 5'd31, 8'hFF, 1'b1);
		add_request(mbs_pkg::FUNC_START, 5'd0, 8'h00, 1'b1);
		add_ticks(2);
		add_request(mbs_pkg::FUNC_STOP, 5'd31, 8'hFF, 1'b1);
		// letter extremes, a non-letter and the last store position
		add_request(mbs_pkg::FUNC_WRITE, 5'd0, mbs_pkg::CHAR_A, 1'b1);
		add_request(mbs_pkg::FUNC_WRITE, 5'd1, mbs_pkg::CHAR_Z, 1'b0);
		add_request(mbs_pkg::FUNC_WRITE, 5'd2, 8'hFF, 1'b0);
		add_request(mbs_pkg::FUNC_WRITE, 5'd31, 8'h80, 1'b1);
		add_request(mbs_pkg::FUNC_START, 5'd0, 8'h00, 1'b0);
		add_ticks(5);
		// stop mid-letter, tick while idle, restart with the letter half sent
		add_request(mbs_pkg::FUNC_STOP, 5'd0, 8'h00, 1'b0);
		add_request(mbs_pkg::FUNC_TICK, 5'd0, 8'h00, 1'b0);
		add_request(mbs_pkg::FUNC_START, 5'd0, 8'h00, 1'b1);
		add_ticks(6);

		while (pending_requests.size() < DIRECTED_MAX + RANDOM_ITEMS) begin
			kind = $urandom_range(0, 99);
			if (kind < 70) begin
				// well-formed message, start, and enough ticks to reach its end
				len = ($urandom_range(0, 14) == 0) ? DEPTH : $urandom_range(0, 8);
				budget = 4;
				for (int k = 0; k < len; k++) begin
					if ($urandom_range(0, 9) < 7) ch = 8'(mbs_pkg::CHAR_A + $urandom_range(0, 25));
					else ch = 8'($urandom_range(1, 255));
					add_request(mbs_pkg::FUNC_WRITE, 5'(k), ch, 1'($urandom));
					budget += int'((ch >= mbs_pkg::CHAR_A && ch <= mbs_pkg::CHAR_Z) ?
						KEY_LEN[5'(ch - mbs_pkg::CHAR_A)] : mbs_pkg::BLANK_BITS);
				end
				if (len < DEPTH)
					add_request(mbs_pkg::FUNC_WRITE, 5'(len), mbs_pkg::CHAR_NUL, 1'($urandom));
				rep = 1'($urandom_range(0, 1));
				add_request(mbs_pkg::FUNC_START, 5'($urandom), 8'($urandom), rep);
				n = budget + $urandom_range(0, rep ? budget : 8);
				for (int k = 0; k < n; k++) begin
					if ($urandom_range(0, 59) == 0)
						add_request(mbs_pkg::FUNC_WRITE, 5'($urandom),
							8'(mbs_pkg::CHAR_A + $urandom_range(0, 25)), 1'($urandom));
					else
						add_request(mbs_pkg::FUNC_TICK, 5'($urandom), 8'($urandom),
							1'($urandom));
				end
				if ($urandom_range(0, 3) == 0)
					add_request(mbs_pkg::FUNC_STOP, 5'($urandom), 8'($urandom), 1'($urandom));
			end else if (kind < 85) begin
				// noise over every field
				n = $urandom_range(1, 10);
				for (int k = 0; k < n; k++)
					add_request(mbs_pkg::func_t'($urandom_range(0, 3)), 5'($urandom),
						8'($urandom), 1'($urandom));
			end else begin
				// broken playback: start, a few ticks, then stop or start again
				add_request(mbs_pkg::FUNC_START, 5'($urandom), 8'($urandom), 1'($urandom));
				add_ticks($urandom_range(1, 12));
				if ($urandom_range(0, 1) == 0)
					add_request(mbs_pkg::FUNC_STOP, 5'($urandom), 8'($urandom), 1'($urandom));
				else
					add_request(mbs_pkg::FUNC_START, 5'($urandom), 8'($urandom), 1'($urandom));
			end
		end

		// keep the run near the planned number of requests
		while (pending_requests.size() > DIRECTED_MAX + RANDOM_ITEMS)
			void'(pending_requests.pop_back());

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_requests.size() != 0 || drv_valid || expected_levels.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatches == 0 && expected_levels.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
